// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, clocked, with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hdl/mrqp_pkg.sv =====
package mrqp_pkg;

  localparam int unsigned NumQueues  = 4;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CmdDepth   = 2;

  localparam int unsigned QID_W      = 3;
  localparam int unsigned QIDX_W     = $clog2(NumQueues);
  localparam int unsigned PTR_W      = $clog2(QueueDepth);
  localparam int unsigned CNT_W      = $clog2(QueueDepth + 1);
  localparam int unsigned ADDR_W     = $clog2(NumQueues * QueueDepth);
  localparam int unsigned QIU_W      = 3;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUES_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_FIRST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_LAST      = 3'd4;

  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_RECV = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_BADID   = 2'd2
  } status_e;

  typedef struct packed {
    status_e               status;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     addr;
    logic [WordWidth-1:0]  wdata;
  } cmd_t;

endpackage

// ===== hdl/multi_ring_queue_poll.sv =====
// A transaction passes front classify, the command queue and the back storage access
// with registered read before its result can be popped.
// Throughput: 1 transaction per cycle while results are popped; the front updates
// pointers and count in the accept cycle, single-port storage is touched once per item.
// Reset clears pointers, counts, command queue and result valid flag; configuration
// returns to 4 queues of capacity 16; word storage is not cleared.
`include "assert_macros.svh"

module multi_ring_queue_poll (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mrqp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mrqp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  logic                                mode_i,
  input  logic [mrqp_pkg::QID_W-1:0]          queue_id_i,
  input  logic [mrqp_pkg::WordWidth-1:0]      send_value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [1:0]                          status_o,
  output logic [mrqp_pkg::WordWidth-1:0]      recv_value_o
);

  mrqp_pkg::cmd_t front_cmd;
  mrqp_pkg::cmd_t back_cmd;
  logic           req_accept;
  logic           cmd_valid;
  logic           cmd_pop;

  assign req_accept = push && !full;

  mrqp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_accept_i (req_accept),
    .mode_i       (mode_i),
    .queue_id_i   (queue_id_i),
    .send_value_i (send_value_i),
    .cmd_o        (front_cmd)
  );

  mrqp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd)
  );

  mrqp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (cmd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .status_o     (status_o),
    .recv_value_o (recv_value_o)
  );

  `ASSERT_CLK(a_fail_no_data, clk_i, rst_ni,
              (!empty && (status_o != mrqp_pkg::ST_OK)) |-> (recv_value_o == '0))
  `ASSERT_CLK(a_full_has_cmd, clk_i, rst_ni, full |-> cmd_valid)
  `ASSERT_CLK(a_back_drains, clk_i, rst_ni, (cmd_valid && (empty || pop)) |=> !empty)
  `ASSERT_CLK(a_pop_to_empty, clk_i, rst_ni, (pop && !empty && !cmd_valid) |=> empty)
  `ASSERT_NEVER(a_bad_status, clk_i, rst_ni, !empty && (status_o == 2'd3))

endmodule

// ===== hdl/mrqp_front.sv =====
module mrqp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mrqp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mrqp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               req_accept_i,
  input  logic                               mode_i,
  input  logic [mrqp_pkg::QID_W-1:0]         queue_id_i,
  input  logic [mrqp_pkg::WordWidth-1:0]     send_value_i,
  output mrqp_pkg::cmd_t                     cmd_o
);

  logic [mrqp_pkg::QIU_W-1:0]  qiu_q;
  logic [mrqp_pkg::CAP_W-1:0]  cap_q  [mrqp_pkg::NumQueues];
  logic [mrqp_pkg::PTR_W-1:0]  head_q [mrqp_pkg::NumQueues];
  logic [mrqp_pkg::PTR_W-1:0]  tail_q [mrqp_pkg::NumQueues];
  logic [mrqp_pkg::CNT_W-1:0]  cnt_q  [mrqp_pkg::NumQueues];

  logic [mrqp_pkg::QIDX_W-1:0] cfg_sel;
  logic [mrqp_pkg::QIU_W-1:0]  limit;
  logic                        id_ok;
  logic [mrqp_pkg::QIDX_W-1:0] qsel;
  logic [mrqp_pkg::CAP_W-1:0]  cap;
  logic [mrqp_pkg::CNT_W-1:0]  cnt;
  logic [mrqp_pkg::PTR_W-1:0]  ptr;
  logic [mrqp_pkg::CNT_W-1:0]  ptr_inc;
  logic [mrqp_pkg::PTR_W-1:0]  ptr_nxt;
  logic                        q_full;
  logic                        q_empty;
  logic                        go;

  assign cfg_sel = mrqp_pkg::QIDX_W'(cfg_idx_i - mrqp_pkg::CFG_CAP_FIRST);

  always_comb begin
    limit = (qiu_q > mrqp_pkg::QIU_W'(mrqp_pkg::NumQueues)) ?
            mrqp_pkg::QIU_W'(mrqp_pkg::NumQueues) : qiu_q;
    id_ok = (queue_id_i != '0) && (queue_id_i <= limit);
    qsel  = mrqp_pkg::QIDX_W'(queue_id_i - mrqp_pkg::QID_W'(1));
    cap   = (cap_q[qsel] > mrqp_pkg::CAP_W'(mrqp_pkg::QueueDepth)) ?
            mrqp_pkg::CAP_W'(mrqp_pkg::QueueDepth) : cap_q[qsel];
    cnt   = cnt_q[qsel];
    q_full  = cnt >= mrqp_pkg::CNT_W'(cap);
    q_empty = cnt == '0;
    ptr     = (mode_i == mrqp_pkg::MODE_RECV) ? head_q[qsel] : tail_q[qsel];
    ptr_inc = mrqp_pkg::CNT_W'(ptr) + mrqp_pkg::CNT_W'(1);
    ptr_nxt = ((ptr_inc >= mrqp_pkg::CNT_W'(cap)) ||
               (ptr_inc >= mrqp_pkg::CNT_W'(mrqp_pkg::QueueDepth))) ?
              '0 : ptr_inc[mrqp_pkg::PTR_W-1:0];
    go = id_ok && ((mode_i == mrqp_pkg::MODE_RECV) ? !q_empty : !q_full);

    cmd_o.status = !id_ok ? mrqp_pkg::ST_BADID :
                   go     ? mrqp_pkg::ST_OK    : mrqp_pkg::ST_TIMEOUT;
    cmd_o.mem_we = go && (mode_i == mrqp_pkg::MODE_SEND);
    cmd_o.mem_re = go && (mode_i == mrqp_pkg::MODE_RECV);
    cmd_o.addr   = {qsel, ptr};
    cmd_o.wdata  = send_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qiu_q <= mrqp_pkg::QIU_W'(mrqp_pkg::NumQueues);
      for (int i = 0; i < mrqp_pkg::NumQueues; i++) begin
        cap_q[i] <= mrqp_pkg::CAP_W'(mrqp_pkg::QueueDepth);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        mrqp_pkg::CFG_QUEUES_IN_USE: begin
          qiu_q <= cfg_wdata_i[mrqp_pkg::QIU_W-1:0];
        end
        [mrqp_pkg::CFG_CAP_FIRST:mrqp_pkg::CFG_CAP_LAST]: begin
          cap_q[cfg_sel] <= cfg_wdata_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mrqp_pkg::NumQueues; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (req_accept_i && go) begin
      if (mode_i == mrqp_pkg::MODE_RECV) begin
        head_q[qsel] <= ptr_nxt;
        cnt_q[qsel]  <= cnt - mrqp_pkg::CNT_W'(1);
      end else begin
        tail_q[qsel] <= ptr_nxt;
        cnt_q[qsel]  <= cnt + mrqp_pkg::CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/mrqp_cmd_fifo.sv =====
module mrqp_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrqp_pkg::cmd_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output mrqp_pkg::cmd_t  data_o
);

  localparam int unsigned IdxW = (mrqp_pkg::CmdDepth > 1) ? $clog2(mrqp_pkg::CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(mrqp_pkg::CmdDepth + 1);

  mrqp_pkg::cmd_t  slot_q [mrqp_pkg::CmdDepth];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(mrqp_pkg::CmdDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == IdxW'(mrqp_pkg::CmdDepth - 1)) ? '0 : wr_q + IdxW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == IdxW'(mrqp_pkg::CmdDepth - 1)) ? '0 : rd_q + IdxW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/mrqp_back.sv =====
module mrqp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  mrqp_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [1:0]                      status_o,
  output logic [mrqp_pkg::WordWidth-1:0]  recv_value_o
);

  logic [mrqp_pkg::WordWidth-1:0] mem_q [mrqp_pkg::NumQueues * mrqp_pkg::QueueDepth];
  logic [mrqp_pkg::WordWidth-1:0] rd_q;
  logic                           res_valid_q, res_valid_d;
  mrqp_pkg::status_e              status_q;
  logic                           is_rd_q;
  logic                           take;

  assign take      = cmd_valid_i && (!res_valid_q || pop_i);
  assign cmd_pop_o = take;

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (take && cmd_i.mem_we) begin
      mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
    if (take && cmd_i.mem_re) begin
      rd_q <= mem_q[cmd_i.addr];
    end
    if (take) begin
      status_q <= cmd_i.status;
      is_rd_q  <= cmd_i.mem_re;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  assign empty_o      = !res_valid_q;
  assign status_o     = status_q;
  assign recv_value_o = is_rd_q ? rd_q : '0;

endmodule
